@@ rtl/core/ppid_pkg.sv @@
package ppid_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned PC_W   = 4;

	localparam logic [2:0] REG_GAIN_P     = 3'd0;
	localparam logic [2:0] REG_GAIN_I     = 3'd1;
	localparam logic [2:0] REG_GAIN_D     = 3'd2;
	localparam logic [2:0] REG_TARGET     = 3'd3;
	localparam logic [2:0] REG_OUT_HIGH   = 3'd4;
	localparam logic [2:0] REG_OUT_LOW    = 3'd5;
	localparam logic [2:0] REG_SUM_HIGH   = 3'd6;
	localparam logic [2:0] REG_SUM_LOW    = 3'd7;

	localparam logic [19:0]        RST_GAIN_P   = 20'd12288;
	localparam logic [19:0]        RST_GAIN_I   = 20'd0;
	localparam logic [19:0]        RST_GAIN_D   = 20'd140800;
	localparam logic signed [15:0] RST_TARGET   = 16'sd640;
	localparam logic signed [15:0] RST_OUT_HIGH = 16'sd9000;
	localparam logic signed [15:0] RST_OUT_LOW  = -16'sd9000;
	localparam logic signed [23:0] RST_SUM_HIGH = 24'sd76800;
	localparam logic signed [23:0] RST_SUM_LOW  = -24'sd1152000;

	localparam logic signed [20:0] W_LO = 21'sd26214;
	localparam logic signed [20:0] W_HI = 21'sd39322;
	localparam logic signed [47:0] ROUND_HALF = 48'sd32768;
	localparam logic signed [47:0] SLOPE_MAX  = 48'sd33554431;
	localparam logic signed [47:0] SLOPE_MIN  = -48'sd33554432;

	localparam logic [PC_W-1:0] STEP_ERR   = 4'd0;
	localparam logic [PC_W-1:0] STEP_SUM   = 4'd1;
	localparam logic [PC_W-1:0] STEP_FLT0  = 4'd2;
	localparam logic [PC_W-1:0] STEP_FLT1  = 4'd3;
	localparam logic [PC_W-1:0] STEP_RND   = 4'd4;
	localparam logic [PC_W-1:0] STEP_ACC0  = 4'd5;
	localparam logic [PC_W-1:0] STEP_ACC1  = 4'd6;
	localparam logic [PC_W-1:0] STEP_OUT   = 4'd7;
	localparam logic [PC_W-1:0] STEP_CLR   = 4'd8;

	typedef enum logic [2:0] {
		MUL_NONE       = 3'd0,
		MUL_WHI_SLOPE  = 3'd1,
		MUL_WLO_DRAW   = 3'd2,
		MUL_GP_ERR     = 3'd3,
		MUL_GI_SUM     = 3'd4,
		MUL_GD_SLOPE   = 3'd5
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD     = 2'd0,
		ACC_LOAD     = 2'd1,
		ACC_ADD      = 2'd2,
		ACC_ADD_SHR8 = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT   = 2'd0,
		SEQ_BR_CLR = 2'd1,
		SEQ_END    = 2'd2
	} seq_t;

	typedef struct packed {
		mul_sel_t        mul_sel;
		acc_op_t         acc_op;
		logic            ld_err;
		logic            ld_sum;
		logic            ld_slope;
		logic            ld_out;
		logic            clr;
		seq_t            seq;
		logic [PC_W-1:0] target;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, ld_err: 1'b0, ld_sum: 1'b0,
			ld_slope: 1'b0, ld_out: 1'b0, clr: 1'b0, seq: SEQ_NEXT, target: STEP_ERR};
		unique case (pc)
			STEP_ERR: begin
				w.ld_err = 1'b1;
				w.seq    = SEQ_BR_CLR;
				w.target = STEP_CLR;
			end
			STEP_SUM: begin
				w.ld_sum  = 1'b1;
				w.mul_sel = MUL_WHI_SLOPE;
			end
			STEP_FLT0: begin
				w.mul_sel = MUL_WLO_DRAW;
				w.acc_op  = ACC_LOAD;
			end
			STEP_FLT1: begin
				w.mul_sel = MUL_GP_ERR;
				w.acc_op  = ACC_ADD;
			end
			STEP_RND: begin
				w.ld_slope = 1'b1;
				w.mul_sel  = MUL_GI_SUM;
				w.acc_op   = ACC_LOAD;
			end
			STEP_ACC0: begin
				w.mul_sel = MUL_GD_SLOPE;
				w.acc_op  = ACC_ADD;
			end
			STEP_ACC1: begin
				w.acc_op = ACC_ADD_SHR8;
			end
			STEP_OUT: begin
				w.ld_out = 1'b1;
				w.seq    = SEQ_END;
			end
			STEP_CLR: begin
				w.clr = 1'b1;
				w.seq = SEQ_END;
			end
			default: begin
				w.seq = SEQ_END;
			end
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/positional_pid_filtered_derivative.sv @@
// A control item runs eight microcode steps, ERR through OUT; a clear item runs ERR
// and CLR. The steps share one 21x26 multiplier and one accumulator, and in_stall
// stays high, so no new item is accepted, until the final step has run.
// The final step holds while a previous result is still waiting to be taken.
// Reset (arst_n low, asynchronous) zeroes the controller state, loads the register
// defaults and leaves the block idle with no result pending.
module positional_pid_filtered_derivative
	import ppid_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic signed [15:0]       measured_position,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [15:0]       correction
);

	logic [19:0]        gain_p_q, gain_i_q, gain_d_q;
	logic signed [15:0] target_q, out_high_q, out_low_q;
	logic signed [23:0] sum_high_q, sum_low_q;

	logic signed [23:0] error_sum_q;
	logic signed [16:0] prev_err_q;
	logic signed [25:0] slope_q;

	logic               busy_q;
	logic [PC_W-1:0]    pc_q;
	logic               action_q;
	logic signed [15:0] meas_q;
	logic signed [16:0] err_q;
	logic signed [17:0] draw_q;
	logic signed [46:0] prod_q;
	logic signed [47:0] acc_q;
	logic               out_valid_q;
	logic signed [15:0] correction_q;

	ctrl_t              uc;
	logic               step_en;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	logic signed [20:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [46:0] mul_p;
	logic signed [16:0] err_d;
	logic signed [17:0] draw_d;
	logic signed [24:0] sum_raw;
	logic signed [23:0] sum_d;
	logic signed [47:0] rnd_t;
	logic signed [47:0] rnd_s;
	logic signed [25:0] slope_d;
	logic signed [47:0] y_s;
	logic signed [47:0] out_high_x, out_low_x;
	logic signed [15:0] y_d;
	logic signed [47:0] prod_x;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign cfg_idx   = paddr[4:2];
	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign correction = correction_q;

	assign uc      = ucode(pc_q);
	assign step_en = busy_q && !(uc.seq == SEQ_END && out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= RST_GAIN_P;
			gain_i_q   <= RST_GAIN_I;
			gain_d_q   <= RST_GAIN_D;
			target_q   <= RST_TARGET;
			out_high_q <= RST_OUT_HIGH;
			out_low_q  <= RST_OUT_LOW;
			sum_high_q <= RST_SUM_HIGH;
			sum_low_q  <= RST_SUM_LOW;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_GAIN_P:   gain_p_q   <= pwdata[19:0];
				REG_GAIN_I:   gain_i_q   <= pwdata[19:0];
				REG_GAIN_D:   gain_d_q   <= pwdata[19:0];
				REG_TARGET:   target_q   <= pwdata[15:0];
				REG_OUT_HIGH: out_high_q <= pwdata[15:0];
				REG_OUT_LOW:  out_low_q  <= pwdata[15:0];
				REG_SUM_HIGH: sum_high_q <= pwdata[23:0];
				REG_SUM_LOW:  sum_low_q  <= pwdata[23:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_GAIN_P:   prdata = {12'd0, gain_p_q};
			REG_GAIN_I:   prdata = {12'd0, gain_i_q};
			REG_GAIN_D:   prdata = {12'd0, gain_d_q};
			REG_TARGET:   prdata = {{16{target_q[15]}}, target_q};
			REG_OUT_HIGH: prdata = {{16{out_high_q[15]}}, out_high_q};
			REG_OUT_LOW:  prdata = {{16{out_low_q[15]}}, out_low_q};
			REG_SUM_HIGH: prdata = {{8{sum_high_q[23]}}, sum_high_q};
			REG_SUM_LOW:  prdata = {{8{sum_low_q[23]}}, sum_low_q};
		endcase
	end

	always_comb begin
		unique case (uc.mul_sel)
			MUL_WHI_SLOPE: begin
				mul_a = W_HI;
				mul_b = slope_q;
			end
			MUL_WLO_DRAW: begin
				mul_a = W_LO;
				mul_b = {draw_q, 8'd0};
			end
			MUL_GP_ERR: begin
				mul_a = {1'b0, gain_p_q};
				mul_b = {{9{err_q[16]}}, err_q};
			end
			MUL_GI_SUM: begin
				mul_a = {1'b0, gain_i_q};
				mul_b = {{2{error_sum_q[23]}}, error_sum_q};
			end
			MUL_GD_SLOPE: begin
				mul_a = {1'b0, gain_d_q};
				mul_b = slope_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign err_d  = {meas_q[15], meas_q} - {target_q[15], target_q};
	assign draw_d = {err_q[16], err_q} - {prev_err_q[16], prev_err_q};

	assign sum_raw = {error_sum_q[23], error_sum_q} + {{8{err_q[16]}}, err_q};
	always_comb begin
		priority if (sum_raw > $signed({sum_high_q[23], sum_high_q})) begin
			sum_d = sum_high_q;
		end else if (sum_raw < $signed({sum_low_q[23], sum_low_q})) begin
			sum_d = sum_low_q;
		end else begin
			sum_d = sum_raw[23:0];
		end
	end

	assign rnd_t = acc_q + ROUND_HALF;
	assign rnd_s = rnd_t >>> 16;
	always_comb begin
		priority if (rnd_s > SLOPE_MAX) begin
			slope_d = SLOPE_MAX[25:0];
		end else if (rnd_s < SLOPE_MIN) begin
			slope_d = SLOPE_MIN[25:0];
		end else begin
			slope_d = rnd_s[25:0];
		end
	end

	assign y_s        = acc_q >>> 16;
	assign out_high_x = {{32{out_high_q[15]}}, out_high_q};
	assign out_low_x  = {{32{out_low_q[15]}}, out_low_q};
	always_comb begin
		priority if (y_s > out_high_x) begin
			y_d = out_high_q;
		end else if (y_s < out_low_x) begin
			y_d = out_low_q;
		end else begin
			y_d = y_s[15:0];
		end
	end

	assign prod_x = {prod_q[46], prod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= STEP_ERR;
			out_valid_q <= 1'b0;
			error_sum_q <= '0;
			prev_err_q  <= '0;
			slope_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (in_valid) begin
					busy_q <= 1'b1;
					pc_q   <= STEP_ERR;
				end
			end else if (step_en) begin
				unique case (uc.seq)
					SEQ_NEXT:   pc_q <= pc_q + 1'b1;
					SEQ_BR_CLR: pc_q <= action_q ? uc.target : pc_q + 1'b1;
					SEQ_END: begin
						busy_q      <= 1'b0;
						out_valid_q <= 1'b1;
					end
					default:    busy_q <= 1'b0;
				endcase
				if (uc.ld_sum) begin
					error_sum_q <= sum_d;
				end
				if (uc.ld_slope) begin
					slope_q <= slope_d;
				end
				if (uc.ld_out) begin
					prev_err_q <= err_q;
				end
				if (uc.clr) begin
					error_sum_q <= '0;
					prev_err_q  <= '0;
					slope_q     <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			action_q <= action;
			meas_q   <= measured_position;
		end
		if (step_en) begin
			prod_q <= mul_p;
			if (uc.ld_err) begin
				err_q <= err_d;
			end
			if (uc.ld_sum) begin
				draw_q <= draw_d;
			end
			unique case (uc.acc_op)
				ACC_HOLD:     acc_q <= acc_q;
				ACC_LOAD:     acc_q <= prod_x;
				ACC_ADD:      acc_q <= acc_q + prod_x;
				ACC_ADD_SHR8: acc_q <= acc_q + (prod_x >>> 8);
			endcase
			if (uc.ld_out) begin
				correction_q <= y_d;
			end
			if (uc.clr) begin
				correction_q <= '0;
			end
		end
	end

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q <= STEP_CLR))
		else $error("step counter left the program");

	a_clear_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && uc.clr) |=> (out_valid && correction == 16'sd0 && error_sum_q == 24'sd0
			&& slope_q == 26'sd0))
		else $error("clear item did not give a zero result and zero state");

	a_sum_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && uc.ld_sum && sum_low_q <= sum_high_q) |=>
			(error_sum_q <= sum_high_q && error_sum_q >= sum_low_q))
		else $error("error sum outside its limits");

	a_result_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && uc.ld_out && out_low_q <= out_high_q) |=>
			(correction <= out_high_q && correction >= out_low_q))
		else $error("correction outside its limits");

endmodule
